FILE: rtl/core/irm_pkg.sv
// Shared types and codes for the I2C register master.
package irm_pkg;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

	// Sequencer phase codes
	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_S1   = 5'd1;
	localparam logic [4:0] PH_S2   = 5'd2;
	localparam logic [4:0] PH_S3   = 5'd3;
	localparam logic [4:0] PH_WD   = 5'd4;
	localparam logic [4:0] PH_WH   = 5'd5;
	localparam logic [4:0] PH_WL   = 5'd6;
	localparam logic [4:0] PH_AR   = 5'd7;
	localparam logic [4:0] PH_AH   = 5'd8;
	localparam logic [4:0] PH_AS   = 5'd9;
	localparam logic [4:0] PH_RH   = 5'd10;
	localparam logic [4:0] PH_RL   = 5'd11;
	localparam logic [4:0] PH_KS   = 5'd12;
	localparam logic [4:0] PH_KH   = 5'd13;
	localparam logic [4:0] PH_KL   = 5'd14;
	localparam logic [4:0] PH_T1   = 5'd15;
	localparam logic [4:0] PH_T2   = 5'd16;
	localparam logic [4:0] PH_T3   = 5'd17;
	localparam logic [4:0] PH_DONE = 5'd18;

	// Which byte the write phases are sending
	localparam logic [1:0] KIND_ADDRW = 2'd0;
	localparam logic [1:0] KIND_REG   = 2'd1;
	localparam logic [1:0] KIND_ADDRR = 2'd2;
	localparam logic [1:0] KIND_DATA  = 2'd3;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic        start_req;
		logic        req_type;
		logic [6:0]  device_address;
		logic [7:0]  register_address;
		logic [15:0] byte_count;
		logic [7:0]  tx_byte;
		logic        sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       tx_take;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       done_res;
		logic       success;
	} res_t;

endpackage

FILE: rtl/core/irm_core.sv
// Bus sequencer state and its one-tick step logic.
module irm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  irm_pkg::req_t      req,
	input  logic [15:0]        half_period,
	output irm_pkg::res_t      res
);
	import irm_pkg::*;

	logic [4:0]  phase_q, phase_d;
	logic [15:0] wait_q, wait_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] left_q, left_d;
	logic [6:0]  dev_q, dev_d;
	logic [7:0]  reg_q, reg_d;
	logic        rd_q, rd_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        fail_q, fail_d;
	logic [1:0]  kind_q, kind_d;

	always_comb begin
		logic [7:0]  sh;
		logic [15:0] left_dec;
		logic [3:0]  bit_inc;
		phase_d = phase_q;
		wait_d  = wait_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		left_d  = left_q;
		dev_d   = dev_q;
		reg_d   = reg_q;
		rd_d    = rd_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		fail_d  = fail_q;
		kind_d  = kind_q;
		res     = '0;
		sh       = shift_q;
		left_dec = (left_q != 16'd0) ? left_q - 16'd1 : left_q;
		bit_inc  = bit_q + 4'd1;

		if (phase_q != PH_IDLE && phase_q != PH_DONE && wait_q != 16'd0) begin
			wait_d = wait_q - 16'd1;
		end else begin
			// every phase change reloads the wait; idle and done overwrite it below
			wait_d = half_period;
			unique case (phase_q)
				PH_IDLE: begin
					wait_d = wait_q;
					if (req.start_req) begin
						dev_d   = req.device_address;
						reg_d   = req.register_address;
						rd_d    = req.req_type;
						left_d  = req.byte_count;
						fail_d  = 1'b0;
						kind_d  = KIND_ADDRW;
						sda_d   = 1'b1;
						scl_d   = 1'b1;
						phase_d = PH_S2;
						wait_d  = half_period;
					end
				end
				PH_S1: begin
					sda_d = 1'b1; scl_d = 1'b1; phase_d = PH_S2;
				end
				PH_S2: begin
					sda_d = 1'b0; phase_d = PH_S3;
				end
				PH_S3: begin
					scl_d = 1'b0; bit_d = 4'd0; phase_d = PH_WD;
				end
				PH_WD: begin
					if (bit_q == 4'd0) begin
						unique case (kind_q)
							KIND_ADDRW: sh = {dev_q, 1'b0};
							KIND_REG:   sh = reg_q;
							KIND_ADDRR: sh = {dev_q, 1'b1};
							default: begin
								sh = req.tx_byte;
								res.tx_take = 1'b1;
							end
						endcase
					end
					sda_d   = sh[7];
					shift_d = {sh[6:0], 1'b0};
					phase_d = PH_WH;
				end
				PH_WH: begin
					scl_d = 1'b1; phase_d = PH_WL;
				end
				PH_WL: begin
					scl_d   = 1'b0;
					bit_d   = bit_inc;
					phase_d = (bit_inc >= BITS_PER_BYTE) ? PH_AR : PH_WD;
				end
				PH_AR: begin
					sda_d = 1'b1; phase_d = PH_AH;
				end
				PH_AH: begin
					scl_d = 1'b1; phase_d = PH_AS;
				end
				PH_AS: begin
					scl_d = 1'b0;
					bit_d = 4'd0;
					priority if (req.sda_in) begin
						fail_d  = 1'b1;
						phase_d = PH_T1;
					end else if (kind_q == KIND_ADDRW) begin
						kind_d  = KIND_REG;
						phase_d = PH_WD;
					end else if (kind_q == KIND_REG) begin
						priority if (rd_q) begin
							kind_d  = KIND_ADDRR;
							phase_d = PH_S1;
						end else if (left_q == 16'd0) begin
							phase_d = PH_T1;
						end else begin
							kind_d  = KIND_DATA;
							phase_d = PH_WD;
						end
					end else if (kind_q == KIND_ADDRR) begin
						phase_d = (left_q == 16'd0) ? PH_T1 : PH_RH;
					end else begin
						left_d  = left_dec;
						phase_d = (left_dec == 16'd0) ? PH_T1 : PH_WD;
					end
				end
				PH_RH: begin
					sda_d = 1'b1; scl_d = 1'b1; phase_d = PH_RL;
				end
				PH_RL: begin
					sh      = {shift_q[6:0], req.sda_in};
					shift_d = sh;
					scl_d   = 1'b0;
					bit_d   = bit_inc;
					if (bit_inc >= BITS_PER_BYTE) begin
						res.rx_valid = 1'b1;
						res.rx_byte  = sh;
						phase_d      = PH_KS;
					end else begin
						phase_d = PH_RH;
					end
				end
				PH_KS: begin
					// ACK all bytes but the last
					sda_d   = (left_q > 16'd1) ? 1'b0 : 1'b1;
					phase_d = PH_KH;
				end
				PH_KH: begin
					scl_d = 1'b1; phase_d = PH_KL;
				end
				PH_KL: begin
					scl_d   = 1'b0;
					bit_d   = 4'd0;
					left_d  = left_dec;
					phase_d = (left_dec == 16'd0) ? PH_T1 : PH_RH;
				end
				PH_T1: begin
					sda_d = 1'b0; phase_d = PH_T2;
				end
				PH_T2: begin
					scl_d = 1'b1; phase_d = PH_T3;
				end
				PH_T3: begin
					sda_d = 1'b1; phase_d = PH_DONE;
				end
				PH_DONE: begin
					res.done_res = 1'b1;
					res.success  = ~fail_q;
					phase_d      = PH_IDLE;
					wait_d       = 16'd0;
				end
				default: begin
					phase_d = PH_IDLE;
					wait_d  = 16'd0;
				end
			endcase
		end

		res.scl_out  = scl_d;
		res.sda_out  = sda_d;
		res.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			left_q  <= '0;
			dev_q   <= '0;
			reg_q   <= '0;
			rd_q    <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			fail_q  <= 1'b0;
			kind_q  <= KIND_ADDRW;
		end else if (en) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			left_q  <= left_d;
			dev_q   <= dev_d;
			reg_q   <= reg_d;
			rd_q    <= rd_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			fail_q  <= fail_d;
			kind_q  <= kind_d;
		end
	end

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BITS_PER_BYTE)
		else $error("bit counter beyond one byte");

	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> scl_q && sda_q)
		else $error("lines not released in idle");

	a_wait_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(phase_q) && $stable(wait_q))
		else $error("sequencer moved without a tick");

endmodule

FILE: rtl/core/i2c_register_master.sv
// Top level of the bit-banged I2C register master.
//
// Each transfer on the req channel is one timer tick: the sampled SDA level and,
// when start_req is set in idle, a register write or read request. Every tick
// yields exactly one transfer on the res channel with the SCL and SDA drives
// (1 released), busy, tx_take, a received byte with rx_valid, and done with
// success at the end of a transaction.
// A tick passes an input register, then one step of the bus sequencer into the
// result register, and one tick is taken every cycle while res is not stalled.
// Between line changes the sequencer counts half_period ticks; cfg_we loads
// half_period from cfg_wdata and the new value applies at the next line change.
// While res_stall is high the result holds and req_stall rises once the input
// register is full; nothing is dropped.
// Reset clears the valid bits of both registers, releases both lines in the
// sequencer, sets half_period to 100 and leaves the sequencer idle.
module i2c_register_master (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  irm_pkg::req_t  req,
	output logic           res_valid,
	input  logic           res_stall,
	output irm_pkg::res_t  res,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata
);
	import irm_pkg::*;

	logic        valid_s1;
	req_t        req_s1;
	logic        adv;
	logic        take;
	logic [15:0] half_period_q;
	res_t        step_res;
	res_t        res_q;
	logic        res_valid_q;

	assign adv       = valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !adv;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			half_period_q <= cfg_wdata;
		end
	end

	irm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.req         (req_s1),
		.half_period (half_period_q),
		.res         (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= step_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done reported while still busy");

	a_success_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.success |-> res_q.done_res)
		else $error("success without done");

	a_take_rx_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.tx_take && res_q.rx_valid))
		else $error("tx and rx byte in one tick");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_s1))
		else $error("stalled tick lost from input register");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the I2C register master: directed and random bus transactions.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import irm_pkg::*;

	localparam int RANDOM_TICKS = 150;
	localparam int QUIET_LIMIT  = 3000;
	localparam int CFG_SETTLE   = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// Sequencer mirror
	logic [15:0] half_per;
	logic [4:0]  seq_phase;
	logic [15:0] hold_cnt;
	logic [3:0]  bit_cnt;
	logic [7:0]  shifter;
	logic [15:0] bytes_rem;
	logic [6:0]  dev_q;
	logic [7:0]  reg_q;
	logic        is_read;
	logic        scl_q;
	logic        sda_q;
	logic        nack_seen;
	logic [1:0]  kind;

	res_t tick_results[$];

	int  mismatches = 0;
	int  quiet_cycles = 0;
	int  ticks_sent = 0;
	int  writes_done = 0;
	int  reads_done = 0;
	int  nacks_done = 0;
	int  data_bytes = 0;
	int  stall_left = 0;
	bit  gaps_on = 1'b1;
	bit  stalls_on = 1'b1;

	i2c_register_master i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic void clear_sequencer();
		half_per = HALF_PERIOD_RESET;
		seq_phase = PH_IDLE;
		hold_cnt = '0;
		bit_cnt = '0;
		shifter = '0;
		bytes_rem = '0;
		dev_q = '0;
		reg_q = '0;
		is_read = 1'b0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		nack_seen = 1'b0;
		kind = KIND_ADDRW;
	endfunction

	function automatic void move_to(input logic [4:0] nxt);
		seq_phase = nxt;
		hold_cnt = half_per;
	endfunction

	// One tick of the bus sequencer; returns the drives and flags for that tick
	function automatic res_t advance_sequencer(input req_t t);
		res_t r;
		logic [4:0] nxt;
		r = '0;
		nxt = PH_IDLE;
		if (seq_phase != PH_IDLE && seq_phase != PH_DONE && hold_cnt != 16'd0) begin
			hold_cnt = hold_cnt - 16'd1;
		end else begin
			case (seq_phase)
			PH_IDLE: begin
				if (t.start_req) begin
					dev_q = t.device_address;
					reg_q = t.register_address;
					is_read = t.req_type;
					bytes_rem = t.byte_count;
					nack_seen = 1'b0;
					kind = KIND_ADDRW;
					sda_q = 1'b1;
					scl_q = 1'b1;
					move_to(PH_S2);
				end
			end
			PH_S1: begin
				sda_q = 1'b1;
				scl_q = 1'b1;
				move_to(PH_S2);
			end
			PH_S2: begin
				sda_q = 1'b0;
				move_to(PH_S3);
			end
			PH_S3: begin
				scl_q = 1'b0;
				bit_cnt = '0;
				move_to(PH_WD);
			end
			PH_WD: begin
				if (bit_cnt == 4'd0) begin
					case (kind)
					KIND_ADDRW: shifter = {dev_q, 1'b0};
					KIND_REG: shifter = reg_q;
					KIND_ADDRR: shifter = {dev_q, 1'b1};
					default: begin
						shifter = t.tx_byte;
						r.tx_take = 1'b1;
					end
					endcase
				end
				sda_q = shifter[7];
				shifter = {shifter[6:0], 1'b0};
				move_to(PH_WH);
			end
			PH_WH: begin
				scl_q = 1'b1;
				move_to(PH_WL);
			end
			PH_WL: begin
				scl_q = 1'b0;
				bit_cnt = bit_cnt + 4'd1;
				move_to(bit_cnt >= BITS_PER_BYTE ? PH_AR : PH_WD);
			end
			PH_AR: begin
				sda_q = 1'b1;
				move_to(PH_AH);
			end
			PH_AH: begin
				scl_q = 1'b1;
				move_to(PH_AS);
			end
			PH_AS: begin
				scl_q = 1'b0;
				bit_cnt = '0;
				if (t.sda_in) begin
					nack_seen = 1'b1;
					nxt = PH_T1;
				end else if (kind == KIND_ADDRW) begin
					kind = KIND_REG;
					nxt = PH_WD;
				end else if (kind == KIND_REG) begin
					if (is_read) begin
						kind = KIND_ADDRR;
						nxt = PH_S1;
					end else if (bytes_rem == 16'd0) begin
						nxt = PH_T1;
					end else begin
						kind = KIND_DATA;
						nxt = PH_WD;
					end
				end else if (kind == KIND_ADDRR) begin
					nxt = (bytes_rem == 16'd0) ? PH_T1 : PH_RH;
				end else begin
					if (bytes_rem != 16'd0) bytes_rem = bytes_rem - 16'd1;
					nxt = (bytes_rem == 16'd0) ? PH_T1 : PH_WD;
				end
				move_to(nxt);
			end
			PH_RH: begin
				sda_q = 1'b1;
				scl_q = 1'b1;
				move_to(PH_RL);
			end
			PH_RL: begin
				shifter = {shifter[6:0], t.sda_in};
				scl_q = 1'b0;
				bit_cnt = bit_cnt + 4'd1;
				if (bit_cnt >= BITS_PER_BYTE) begin
					r.rx_valid = 1'b1;
					r.rx_byte = shifter;
					move_to(PH_KS);
				end else begin
					move_to(PH_RH);
				end
			end
			PH_KS: begin
				// ACK every byte but the last
				sda_q = (bytes_rem > 16'd1) ? 1'b0 : 1'b1;
				move_to(PH_KH);
			end
			PH_KH: begin
				scl_q = 1'b1;
				move_to(PH_KL);
			end
			PH_KL: begin
				scl_q = 1'b0;
				bit_cnt = '0;
				if (bytes_rem != 16'd0) bytes_rem = bytes_rem - 16'd1;
				move_to(bytes_rem == 16'd0 ? PH_T1 : PH_RH);
			end
			PH_T1: begin
				sda_q = 1'b0;
				move_to(PH_T2);
			end
			PH_T2: begin
				scl_q = 1'b1;
				move_to(PH_T3);
			end
			PH_T3: begin
				sda_q = 1'b1;
				move_to(PH_DONE);
			end
			PH_DONE: begin
				r.done_res = 1'b1;
				r.success = !nack_seen;
				seq_phase = PH_IDLE;
				hold_cnt = '0;
			end
			default: begin
				seq_phase = PH_IDLE;
				hold_cnt = '0;
			end
			endcase
		end
		r.scl_out = scl_q;
		r.sda_out = sda_q;
		r.busy_res = (seq_phase != PH_IDLE);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (!gaps_on || r < 60) return 0;
		if (r < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic req_t random_item();
		req_t it;
		it.start_req = 1'b0;
		it.req_type = 1'($urandom);
		it.device_address = 7'($urandom);
		it.register_address = 8'($urandom);
		it.byte_count = 16'($urandom);
		it.tx_byte = 8'($urandom);
		it.sda_in = 1'($urandom);
		return it;
	endfunction

	function automatic logic [15:0] random_half_period();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 16'd0;
		return 16'($urandom_range(3, 1));
	endfunction

	// Send one tick; called and returns at a falling edge
	task automatic push_tick(input req_t it, output res_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = it;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		want = advance_sequencer(it);
		tick_results.push_back(want);
		ticks_sent++;
		if (want.tx_take || want.rx_valid) data_bytes++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		req_valid = 1'b0;
		while (tick_results.size() != 0) @(negedge clk);
	endtask

	task automatic set_half_period(input logic [15:0] value);
		wait_for_results();
		// let the last tick clear the input register and sequencer
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		half_per = value;
	endtask

	task automatic idle_ticks(input int n);
		res_t got;
		repeat (n) push_tick(random_item(), got);
	endtask

	// Run one bus transaction from idle to its done tick; ACK every slave ACK slot
	// except the one numbered nack_at
	task automatic run_transaction(input logic rd, input logic [6:0] dev,
		input logic [7:0] reg_idx, input logic [15:0] count, input int nack_at,
		input int noise_pct);
		req_t it;
		res_t got;
		int ack_no;
		ack_no = 0;
		it = random_item();
		it.start_req = 1'b1;
		it.req_type = rd;
		it.device_address = dev;
		it.register_address = reg_idx;
		it.byte_count = count;
		push_tick(it, got);
		do begin
			it = random_item();
			it.start_req = ($urandom_range(99) < noise_pct);
			if (seq_phase == PH_AS && hold_cnt == 16'd0) begin
				it.sda_in = (ack_no == nack_at);
				ack_no++;
			end
			push_tick(it, got);
		end while (!got.done_res);
		if (rd) reads_done++;
		else writes_done++;
		if (!got.success) nacks_done++;
	endtask

	task automatic test_idle_ticks();
		idle_ticks(6);
	endtask

	task automatic test_writes();
		set_half_period(16'd0);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		run_transaction(1'b0, 7'h7F, 8'hFF, 16'd2, -1, 0);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		run_transaction(1'b0, 7'h00, 8'h00, 16'd1, -1, 0);
	endtask

	task automatic test_reads();
		run_transaction(1'b1, 7'h55, 8'hAA, 16'd3, -1, 0);
		run_transaction(1'b1, 7'h7F, 8'h00, 16'd1, -1, 0);
	endtask

	task automatic test_zero_count();
		run_transaction(1'b0, 7'h2A, 8'h81, 16'd0, -1, 0);
		run_transaction(1'b1, 7'h13, 8'h7E, 16'd0, -1, 0);
	endtask

	task automatic test_nacks();
		run_transaction(1'b0, 7'h48, 8'h10, 16'd2, 0, 0);
		run_transaction(1'b1, 7'h21, 8'h33, 16'd2, 1, 0);
		run_transaction(1'b1, 7'h6C, 8'hC3, 16'd2, 2, 0);
		run_transaction(1'b0, 7'h3F, 8'h5A, 16'hFFFF, 3, 0);
	endtask

	task automatic test_busy_requests();
		// raise start_req on every busy tick, the done tick included
		run_transaction(1'b0, 7'h11, 8'h22, 16'd0, -1, 100);
		run_transaction(1'b1, 7'h66, 8'h99, 16'd0, -1, 100);
	endtask

	task automatic test_half_periods();
		set_half_period(16'd1);
		run_transaction(1'b0, 7'h50, 8'h05, 16'd0, -1, 10);
		set_half_period(16'd3);
		run_transaction(1'b1, 7'h0F, 8'hF0, 16'd1, 0, 10);
		set_half_period(16'hFFFF);
		idle_ticks(4);
		set_half_period(HALF_PERIOD_RESET);
		idle_ticks(3);
	endtask

	task automatic test_random_traffic();
		int first_tick;
		logic rd;
		logic [15:0] count;
		int nack_at;
		first_tick = ticks_sent;
		set_half_period(16'd0);
		while (ticks_sent - first_tick < RANDOM_TICKS) begin
			if ($urandom_range(99) < 20) begin
				gaps_on = ($urandom_range(3) != 0);
				stalls_on = ($urandom_range(3) != 0);
			end
			if ($urandom_range(99) < 30) set_half_period(random_half_period());
			else if ($urandom_range(99) < 10) wait_for_results();
			idle_ticks($urandom_range(3));
			rd = 1'($urandom);
			nack_at = -1;
			if (rd) begin
				count = 16'($urandom_range(3));
				if ($urandom_range(99) < 12) nack_at = $urandom_range(2);
			end else if ($urandom_range(99) < 10) begin
				// long write cut short by a NACK on an early data byte
				count = 16'($urandom_range(65535, 256));
				nack_at = $urandom_range(4, 2);
			end else begin
				count = 16'($urandom_range(3));
				if ($urandom_range(99) < 15) nack_at = $urandom_range(count + 1);
			end
			run_transaction(rd, 7'($urandom), 8'($urandom), count, nack_at,
				$urandom_range(30));
		end
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	// Compare each result transfer with the oldest expected tick
	always @(posedge clk) begin
		res_t want;
		if (res_valid && !res_stall) begin
			if (tick_results.size() == 0) begin
				mismatches++;
				$error("result with no tick outstanding");
			end else begin
				want = tick_results.pop_front();
				check_field("scl_out", 8'(want.scl_out), 8'(res.scl_out));
				check_field("sda_out", 8'(want.sda_out), 8'(res.sda_out));
				check_field("busy_res", 8'(want.busy_res), 8'(res.busy_res));
				check_field("tx_take", 8'(want.tx_take), 8'(res.tx_take));
				check_field("rx_valid", 8'(want.rx_valid), 8'(res.rx_valid));
				check_field("rx_byte", want.rx_byte, res.rx_byte);
				check_field("done_res", 8'(want.done_res), 8'(res.done_res));
				check_field("success", 8'(want.success), 8'(res.success));
			end
		end
	end

	// Hold stall for a random stretch, mostly short
	always @(negedge clk) begin
		int r;
		if (stall_left != 0) begin
			stall_left--;
		end else if (!stalls_on) begin
			res_stall = 1'b0;
		end else begin
			r = $urandom_range(99);
			if (r < 60) begin
				res_stall = 1'b0;
			end else if (r < 92) begin
				res_stall = 1'b1;
				stall_left = $urandom_range(2);
			end else begin
				res_stall = 1'b1;
				stall_left = $urandom_range(40, 8);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, tick_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		clear_sequencer();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_ticks();
		test_writes();
		test_reads();
		test_zero_count();
		test_nacks();
		test_busy_requests();
		test_half_periods();
		test_random_traffic();

		wait_for_results();
		repeat (6) @(negedge clk);
		$display("Run covered %0d ticks: %0d writes, %0d reads, %0d ended on a NACK,",
			ticks_sent, writes_done, reads_done, nacks_done);
		$display("%0d data bytes; half periods 0 to 3 on the bus, 65535 written idle.",
			data_bytes);
		if (mismatches == 0 && tick_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/irm_pkg.sv
rtl/core/irm_core.sv
rtl/core/i2c_register_master.sv
verif/tb_top.sv
